FILE: rtl/assert_macros.svh
// Concurrent assertion helpers; define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/dcbpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dcbpt_pkg;

  localparam int unsigned IntervalWidth = 24;
  localparam int unsigned DutyWidth     = 7;
  localparam int unsigned RepeatWidth   = 16;
  localparam int unsigned TimeWidth     = 32;
  localparam int unsigned CfgIndexWidth = 2;

  localparam logic [1:0] CMD_POLL    = 2'd0;
  localparam logic [1:0] CMD_INIT    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_OFF  = 2'd1;
  localparam logic [1:0] EV_ON   = 2'd2;

  localparam logic [CfgIndexWidth-1:0] REG_INTERVAL = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_DUTY     = 2'd1;
  localparam logic [CfgIndexWidth-1:0] REG_REPEAT   = 2'd2;

  localparam logic [IntervalWidth-1:0] INTERVAL_RESET = 24'd1000;
  localparam logic [DutyWidth-1:0]     DUTY_RESET     = 7'd50;
  localparam logic [RepeatWidth-1:0]   REPEAT_RESET   = 16'd10;
  localparam logic [IntervalWidth-1:0] ON_LEN_RESET   = 24'd500;

  localparam logic [DutyWidth-1:0] DUTY_MAX = 7'd99;

  // floor(x / 25) = (x * RECIP_25) >> RECIP_SHIFT for x below 2^29
  localparam logic [29:0] RECIP_25    = 30'd687194768;
  localparam int unsigned RECIP_SHIFT = 34;

  localparam logic [1:0] SETTLE_CYCLES = 2'd3;

  typedef struct packed {
    logic [1:0]           command;
    logic [TimeWidth-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic                   done_res;
    logic [1:0]             phase_event;
    logic [RepeatWidth-1:0] cycles_completed;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/duty_cycle_blink_pattern_timer_core.sv
// Duty-cycle blink pattern timer.
// Input channel (in_valid/in_stall/in_data): each transaction is a poll carrying
// the current millisecond time, an initialise command or a restart command.
// Output channel (out_valid/out_stall/out_data): one result per input
// transaction, giving done, the phase edge taken and the completed cycle count.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 interval,
// 1 duty percent, 2 repeat count; ready is always high.
// The input register feeds the result register; one transaction per cycle is
// sustained unless the receiver stalls or a register write settles, the timer
// state update being a single subtract and compare between the two registers.
// The on and off phase lengths are worked out from the registers by a
// 3-stage multiply-by-reciprocal pipeline; after reset and after every
// register write the input is stalled while that pipeline refills.
// Reset (rst, synchronous) restores the register defaults and clears the timer.
// When the receiver stalls, the result is held and the input register is
// still taken only if it is empty, so at most one item waits behind it.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module duty_cycle_blink_pattern_timer_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire dcbpt_pkg::in_item_t                  in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output dcbpt_pkg::out_item_t                      out_data,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [dcbpt_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  wire logic [dcbpt_pkg::IntervalWidth-1:0]  cfg_data
);
  import dcbpt_pkg::*;

  logic [IntervalWidth-1:0] interval_ms;
  logic [DutyWidth-1:0]     duty_percent;
  logic [RepeatWidth-1:0]   repeat_count;
  logic [1:0]               settle;

  logic [DutyWidth-1:0]     eff_duty;
  logic [30:0]              prod;
  logic [30:0]              prod_d;
  logic [58:0]              recip_prod;
  logic [IntervalWidth-1:0] quot;
  logic [30:0]              quot_x100;
  logic                     rem_nz;
  logic [IntervalWidth-1:0] on_len;
  logic [IntervalWidth-1:0] off_len;

  logic                     in_full;
  in_item_t                 in_q;
  logic                     advance;
  logic                     step;

  logic [TimeWidth-1:0]     start_time;
  logic [TimeWidth-1:0]     elapsed_time;
  logic                     timer_running;
  logic [IntervalWidth-1:0] phase_length;
  logic                     in_off_phase;
  logic [RepeatWidth-1:0]   cycle_counter;
  logic                     finished;

  logic [TimeWidth-1:0]     start_time_next;
  logic [TimeWidth-1:0]     elapsed_time_next;
  logic                     timer_running_next;
  logic [IntervalWidth-1:0] phase_length_next;
  logic                     in_off_phase_next;
  logic [RepeatWidth-1:0]   cycle_counter_next;
  logic                     finished_next;
  logic [1:0]               event_next;
  logic [TimeWidth-1:0]     el;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_ms  <= INTERVAL_RESET;
      duty_percent <= DUTY_RESET;
      repeat_count <= REPEAT_RESET;
      settle       <= SETTLE_CYCLES;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_INTERVAL: interval_ms  <= cfg_data;
        REG_DUTY:     duty_percent <= cfg_data[DutyWidth-1:0];
        REG_REPEAT:   repeat_count <= cfg_data[RepeatWidth-1:0];
        default: ;
      endcase
      settle <= SETTLE_CYCLES;
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  // phase lengths: on = floor(i*d/100), off = i - ceil(i*d/100)
  assign eff_duty   = (duty_percent > DUTY_MAX) ? DUTY_MAX : duty_percent;
  assign recip_prod = prod[30:2] * RECIP_25;
  assign quot_x100  = {1'b0, quot, 6'd0} + {2'b0, quot, 5'd0} + {5'b0, quot, 2'd0};
  assign rem_nz     = (prod_d != quot_x100);

  always_ff @(posedge clk) begin
    prod    <= 31'(interval_ms) * 31'(eff_duty);
    prod_d  <= prod;
    quot    <= recip_prod[RECIP_SHIFT+IntervalWidth-1:RECIP_SHIFT];
    on_len  <= quot;
    off_len <= interval_ms - quot - IntervalWidth'(rem_nz);
  end

  assign advance  = !out_valid || !out_stall;
  assign step     = in_full && advance;
  assign in_stall = (in_full && !advance) || (settle != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= (in_valid && !in_stall) || (in_full && !advance);
    end
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
  end

  assign el = timer_running ? (in_q.now_ms - start_time) : elapsed_time;

  always_comb begin
    start_time_next    = start_time;
    elapsed_time_next  = elapsed_time;
    timer_running_next = timer_running;
    phase_length_next  = phase_length;
    in_off_phase_next  = in_off_phase;
    cycle_counter_next = cycle_counter;
    finished_next      = finished;
    event_next         = EV_NONE;
    unique case (in_q.command)
      CMD_INIT: begin
        finished_next      = 1'b0;
        cycle_counter_next = '0;
        in_off_phase_next  = 1'b0;
        start_time_next    = '0;
        timer_running_next = 1'b0;
        phase_length_next  = on_len;
      end
      CMD_RESTART: begin
        finished_next      = 1'b0;
        cycle_counter_next = '0;
      end
      CMD_POLL: begin
        if (finished || (cycle_counter == repeat_count)) begin
          finished_next = 1'b1;
        end else begin
          timer_running_next = 1'b1;
          start_time_next    = in_q.now_ms - el;
          elapsed_time_next  = el;
          if (el >= TimeWidth'(phase_length)) begin
            start_time_next   = in_q.now_ms;
            elapsed_time_next = '0;
            in_off_phase_next = !in_off_phase;
            if (!in_off_phase) begin
              event_next        = EV_OFF;
              phase_length_next = off_len;
            end else begin
              event_next         = EV_ON;
              phase_length_next  = on_len;
              cycle_counter_next = cycle_counter + 16'd1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_time    <= '0;
      elapsed_time  <= '0;
      timer_running <= 1'b0;
      phase_length  <= ON_LEN_RESET;
      in_off_phase  <= 1'b0;
      cycle_counter <= '0;
      finished      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (step) begin
        start_time    <= start_time_next;
        elapsed_time  <= elapsed_time_next;
        timer_running <= timer_running_next;
        phase_length  <= phase_length_next;
        in_off_phase  <= in_off_phase_next;
        cycle_counter <= cycle_counter_next;
        finished      <= finished_next;
      end
      if (advance) begin
        out_valid <= in_full;
      end
    end
    if (step) begin
      out_data.done_res         <= finished_next;
      out_data.phase_event      <= event_next;
      out_data.cycles_completed <= cycle_counter_next;
    end
  end

  `ASSERT_IMPLIES(a_len_sum, clk, rst, settle == 2'd0,
      ({1'b0, on_len} + {1'b0, off_len}) <= {1'b0, interval_ms})
  `ASSERT_NEXT(a_count_hold, clk, rst, !step, $stable(cycle_counter) && $stable(finished))
  `ASSERT_NEXT(a_on_counts, clk, rst, step && (event_next == EV_ON),
      cycle_counter == ($past(cycle_counter) + 16'd1))
  `ASSERT_ALWAYS(a_done_quiet, clk, rst,
      !(out_valid && out_data.done_res && (out_data.phase_event != EV_NONE)))

endmodule

`default_nettype wire

FILE: tb/blink_timer_check_pkg.sv
`timescale 1ns / 1ps

package blink_timer_check_pkg;
  import dcbpt_pkg::*;

  class blink_timer_model;
    logic [IntervalWidth-1:0] interval_ms;
    logic [DutyWidth-1:0]     duty_pct;
    logic [RepeatWidth-1:0]   repeat_target;
    logic [TimeWidth-1:0]     start_ms;
    logic [TimeWidth-1:0]     elapsed_ms;
    logic [TimeWidth-1:0]     phase_len;
    bit                       running;
    bit                       off_phase;
    bit                       finished;
    logic [RepeatWidth-1:0]   cycles_done;
    out_item_t                expected_status[$];
    int unsigned              errors;

    function new();
      interval_ms   = INTERVAL_RESET;
      duty_pct      = DUTY_RESET;
      repeat_target = REPEAT_RESET;
      start_ms      = '0;
      elapsed_ms    = '0;
      running       = 1'b0;
      off_phase     = 1'b0;
      finished      = 1'b0;
      cycles_done   = '0;
      errors        = 0;
      phase_len     = phase_ms(1'b1);
    endfunction

    function logic [TimeWidth-1:0] phase_ms(bit on_phase);
      longint unsigned pct;
      longint unsigned span;
      logic [TimeWidth-1:0] len;
      span = 64'(interval_ms);
      pct = (duty_pct > DUTY_MAX) ? 64'(DUTY_MAX) : 64'(duty_pct);
      if (!on_phase) begin
        pct = 100 - pct;
      end
      len = TimeWidth'((span * pct) / 100);
      return len;
    endfunction

    function void write_reg(logic [CfgIndexWidth-1:0] idx, logic [IntervalWidth-1:0] val);
      case (idx)
        REG_INTERVAL: begin
          interval_ms = val;
        end
        REG_DUTY: begin
          duty_pct = val[DutyWidth-1:0];
        end
        REG_REPEAT: begin
          repeat_target = val[RepeatWidth-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void take_command(in_item_t cmd_item);
      out_item_t            status;
      logic [TimeWidth-1:0] span;
      status.phase_event = EV_NONE;
      case (cmd_item.command)
        CMD_INIT: begin
          finished    = 1'b0;
          cycles_done = '0;
          off_phase   = 1'b0;
          start_ms    = '0;
          running     = 1'b0;
          phase_len   = phase_ms(1'b1);
        end
        CMD_RESTART: begin
          finished    = 1'b0;
          cycles_done = '0;
        end
        CMD_POLL: begin
          if (!finished) begin
            if (cycles_done == repeat_target) begin
              finished = 1'b1;
            end else begin
              if (!running) begin
                start_ms = cmd_item.now_ms - elapsed_ms;
                running  = 1'b1;
              end
              span = cmd_item.now_ms - start_ms;
              elapsed_ms = span;
              if (span >= phase_len) begin
                start_ms   = cmd_item.now_ms;
                elapsed_ms = '0;
                if (!off_phase) begin
                  status.phase_event = EV_OFF;
                  off_phase = 1'b1;
                  phase_len = phase_ms(1'b0);
                end else begin
                  status.phase_event = EV_ON;
                  off_phase = 1'b0;
                  phase_len = phase_ms(1'b1);
                  cycles_done = cycles_done + 16'd1;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
      status.done_res         = finished;
      status.cycles_completed = cycles_done;
      expected_status.push_back(status);
    endfunction

    function void check_status(out_item_t got);
      out_item_t want;
      if (expected_status.size() == 0) begin
        $error("unexpected result: done_res %0d phase_event %0d cycles_completed %0d",
               got.done_res, got.phase_event, got.cycles_completed);
        errors++;
      end else begin
        want = expected_status.pop_front();
        if (got.done_res !== want.done_res) begin
          $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
          errors++;
        end
        if (got.phase_event !== want.phase_event) begin
          $error("phase_event: expected %0d, got %0d", want.phase_event, got.phase_event);
          errors++;
        end
        if (got.cycles_completed !== want.cycles_completed) begin
          $error("cycles_completed: expected %0d, got %0d",
                 want.cycles_completed, got.cycles_completed);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_status.size();
    endfunction
  endclass

endpackage

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import dcbpt_pkg::*;
  import blink_timer_check_pkg::*;

  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned RandomPhases = 11;
  localparam int unsigned PhaseItems   = 100;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  in_item_t                 in_data   = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  out_item_t                out_data;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [IntervalWidth-1:0] cfg_data  = '0;

  blink_timer_model     timer_model;
  in_item_t             stim_q[$];
  logic [TimeWidth-1:0] now_track   = '0;
  int unsigned          idle_cycles = 0;
  int unsigned          stall_mode  = 0;
  int unsigned          stall_left  = 0;
  int unsigned          stall_tick  = 0;

  duty_cycle_blink_pattern_timer_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(10, 150);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      2: begin
        out_stall <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_stall <= ((stall_tick % 5) < 2);
      end
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        timer_model.take_command(in_data);
      end
      if (out_valid && !out_stall) begin
        timer_model.check_status(out_data);
      end
      if (cfg_valid && cfg_ready) begin
        timer_model.write_reg(cfg_index, cfg_data);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else if (idle_cycles == IdleLimit) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles++;
      end
    end
  end

  function automatic void add_item(logic [1:0] cmd, logic [TimeWidth-1:0] stamp);
    in_item_t it;
    it.command = cmd;
    it.now_ms  = stamp;
    stim_q.push_back(it);
  endfunction

  function automatic void advance_clock(int unsigned span);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 9) begin
      now_track = $urandom;
    end else if (pick == 8) begin
      now_track += $urandom_range(span / 2, span);
    end else if (pick >= 6) begin
      now_track += $urandom_range(0, span + 1);
    end else if (pick >= 1) begin
      now_track += $urandom_range(0, span / 4 + 1);
    end
  endfunction

  task automatic drive_item(in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic play_items();
    int unsigned burst;
    int unsigned gap;
    while (stim_q.size() != 0) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (int unsigned i = 0; i < burst && stim_q.size() != 0; i++) begin
        drive_item(stim_q.pop_front());
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0 || stim_q.size() == 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic set_reg(logic [CfgIndexWidth-1:0] idx, logic [IntervalWidth-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(logic [IntervalWidth-1:0] span, logic [DutyWidth-1:0] duty,
                           logic [RepeatWidth-1:0] target);
    while (timer_model.pending() != 0) @(negedge clk);
    set_reg(REG_INTERVAL, span);
    set_reg(REG_DUTY, IntervalWidth'(duty));
    set_reg(REG_REPEAT, IntervalWidth'(target));
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(logic [IntervalWidth-1:0] span);
    int unsigned pick;
    for (int unsigned n = 0; n < PhaseItems; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        add_item(CMD_INIT, $urandom);
      end else if (pick < 11) begin
        add_item(CMD_RESTART, $urandom);
      end else begin
        advance_clock(32'(span));
        add_item(CMD_POLL, now_track);
      end
    end
    play_items();
  endtask

  initial begin
    logic [IntervalWidth-1:0] span;
    logic [DutyWidth-1:0]     duty;
    logic [RepeatWidth-1:0]   target;
    timer_model = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_item(CMD_POLL, 32'd100);
    add_item(CMD_POLL, 32'd599);
    add_item(CMD_POLL, 32'd600);
    add_item(CMD_POLL, 32'd1100);
    add_item(CMD_INIT, 32'hFFFF_FFFF);
    add_item(CMD_POLL, 32'hFFFF_FF00);
    add_item(CMD_POLL, 32'h0000_00F4);
    add_item(CMD_RESTART, 32'd0);
    add_item(CMD_POLL, 32'hFFFF_FFFF);
    play_items();

    configure('0, '0, 16'd2);
    add_item(CMD_INIT, 32'd0);
    repeat (6) add_item(CMD_POLL, $urandom);
    add_item(CMD_RESTART, 32'd0);
    add_item(CMD_POLL, 32'd0);
    play_items();

    configure('1, DUTY_MAX, '1);
    add_item(CMD_INIT, 32'd0);
    add_item(CMD_POLL, 32'd1000);
    add_item(CMD_POLL, 32'd16610441);
    add_item(CMD_POLL, 32'd16610442);
    add_item(CMD_POLL, 32'd16778213);
    add_item(CMD_INIT, 32'd0);
    add_item(CMD_POLL, 32'd5);
    add_item(CMD_POLL, $urandom);
    play_items();

    for (int unsigned k = 0; k < RandomPhases; k++) begin
      case ($urandom_range(0, 4)) inside
        0: begin
          span = IntervalWidth'($urandom_range(0, 20));
        end
        1, 2: begin
          span = IntervalWidth'($urandom_range(20, 2000));
        end
        3: begin
          span = IntervalWidth'($urandom_range(2000, 100000));
        end
        default: begin
          span = IntervalWidth'($urandom_range(0, 24'hFF_FFFF));
        end
      endcase
      duty   = DutyWidth'($urandom_range(0, DUTY_MAX));
      target = ($urandom_range(0, 9) == 0) ? RepeatWidth'($urandom_range(0, 16'hFFFF))
                                           : RepeatWidth'($urandom_range(1, 8));
      case (k)
        1: begin
          span = '0;
        end
        2: begin
          span   = '1;
          duty   = '0;
          target = 16'd3;
        end
        3: begin
          target = '0;
        end
        4: begin
          span   = 24'd3;
          duty   = DUTY_MAX;
          target = '1;
        end
        5: begin
          span   = 24'd10;
          target = 16'd1;
        end
        6: begin
          duty = 7'd1;
        end
        default: begin
        end
      endcase
      configure(span, duty, target);
      now_track = $urandom;
      random_phase(span);
    end

    while (timer_model.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (timer_model.errors == 0 && timer_model.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/dcbpt_pkg.sv
rtl/duty_cycle_blink_pattern_timer_core.sv
tb/blink_timer_check_pkg.sv
tb/tb.sv
